// ===== design/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg: shared types and constants for the triangle perimeter/area unit.
// Holds the field widths and the data record passed between square-root cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int PERIM_W = 19;
    localparam int AREA_W  = 31;

    // Internal widths.
    localparam int DIFF_W  = COORD_W;          // magnitude of a coordinate difference
    localparam int SQ_W    = 2 * DIFF_W + 1;   // dx^2 + dy^2
    localparam int SIDE_W  = DIFF_W + 1;       // floor square root of SQ_W bits
    localparam int FAC_W   = PERIM_W;          // one positive Heron factor
    localparam int PROD_W  = PERIM_W + FAC_W;  // sum * f1, or f2 * f3
    localparam int HALF_W  = PROD_W / 2;       // low slice of the first product
    localparam int PP_W    = HALF_W + PROD_W;  // one partial product
    localparam int Q_W     = 2 * PROD_W;       // full Heron product

    // Square-root cell widths, sized for the Heron product.
    localparam int RAD_W   = Q_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;

    // Cell counts: one root bit per cell.
    localparam int SIDE_CELLS = SIDE_W;
    localparam int AREA_CELLS = ROOT_W;

    // Pipeline depth from input register to output register.
    localparam int DEPTH = SIDE_CELLS + AREA_CELLS + 6;

    // Data handed from one square-root cell to the next.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_cell;

endpackage

`default_nettype wire

// ===== design/triangle_perimeter_area_unit.sv =====
// Throughput: one item per cycle; the whole pipeline stalls together only
// while the output register holds a result that is not taken.
// Depth is set by the two square-root cell chains: 17 cells for the sides
// and 38 cells for the Heron area root, one root bit per cell.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_perimeter_area_unit: perimeter and Heron area of a triangle.
// Squared side lengths, side roots, Heron factors, two narrow products, split wide
// product, recombined product, the area root and saturated output, each as registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_perimeter_area_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_ax,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_ay,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_bx,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_by_coord,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_cx,
    input  wire logic signed [tpa_pkg::COORD_W-1:0]  i_cy,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [tpa_pkg::PERIM_W-1:0]              o_perimeter,
    output logic [tpa_pkg::AREA_W-1:0]               o_tri_area
);
    import tpa_pkg::*;

    logic             s_en;
    logic [DEPTH-1:0] r_vld;

    // Global stage enable: advance unless a result is stuck at the output.
    assign s_en    = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = s_en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Magnitude of a coordinate difference.
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
        m = d[COORD_W] ? (-d) : d;
        return m[DIFF_W-1:0];
    endfunction

    // Squared side lengths for AB, AC and BC.
    logic [DIFF_W-1:0] s_dx [3];
    logic [DIFF_W-1:0] s_dy [3];
    logic [SQ_W-1:0]   r_sq [3];

    always_comb begin
        s_dx[0] = abs_diff(i_ax, i_bx);
        s_dy[0] = abs_diff(i_ay, i_by_coord);
        s_dx[1] = abs_diff(i_ax, i_cx);
        s_dy[1] = abs_diff(i_ay, i_cy);
        s_dx[2] = abs_diff(i_bx, i_cx);
        s_dy[2] = abs_diff(i_by_coord, i_cy);
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= {1'b0, (2*DIFF_W)'(s_dx[k]) * (2*DIFF_W)'(s_dx[k])}
                         + {1'b0, (2*DIFF_W)'(s_dy[k]) * (2*DIFF_W)'(s_dy[k])};
            end
        end
    end

    // Side square roots: three chains of cells, radicand aligned at the top.
    t_sq_cell s_side [3][SIDE_CELLS+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign s_side[l][0].rad  = {1'b0, r_sq[l], {(RAD_W-SQ_W-1){1'b0}}};
        assign s_side[l][0].rem  = '0;
        assign s_side[l][0].root = '0;
        for (genvar k = 0; k < SIDE_CELLS; k++) begin : g_cell
            tpa_sqrt_cell u_cell (
                .i_clk (i_clk),
                .i_en  (s_en),
                .i_d   (s_side[l][k]),
                .o_q   (s_side[l][k+1])
            );
        end
    end

    // Perimeter and Heron factors.
    logic [SIDE_W-1:0]         s_a, s_b, s_c;
    logic [PERIM_W-1:0]        r_sum;
    logic signed [PERIM_W:0]   r_f1, r_f2, r_f3;

    assign s_a = s_side[0][SIDE_CELLS].root[SIDE_W-1:0];
    assign s_b = s_side[1][SIDE_CELLS].root[SIDE_W-1:0];
    assign s_c = s_side[2][SIDE_CELLS].root[SIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_sum <= PERIM_W'(s_a) + PERIM_W'(s_b) + PERIM_W'(s_c);
            r_f1  <= -$signed({1'b0, (PERIM_W)'(s_a)}) + $signed({1'b0, (PERIM_W)'(s_b)})
                     + $signed({1'b0, (PERIM_W)'(s_c)});
            r_f2  <= $signed({1'b0, (PERIM_W)'(s_a)}) - $signed({1'b0, (PERIM_W)'(s_b)})
                     + $signed({1'b0, (PERIM_W)'(s_c)});
            r_f3  <= $signed({1'b0, (PERIM_W)'(s_a)}) + $signed({1'b0, (PERIM_W)'(s_b)})
                     - $signed({1'b0, (PERIM_W)'(s_c)});
        end
    end

    // Two narrow products; a degenerate triangle gives zero.
    logic               s_pos;
    logic [PROD_W-1:0]  r_p1, r_p2;
    logic [PERIM_W-1:0] r_perim_p;

    assign s_pos = (r_f1 > 0) && (r_f2 > 0) && (r_f3 > 0);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_perim_p <= r_sum;
            if (s_pos) begin
                r_p1 <= r_sum * r_f1[FAC_W-1:0];
                r_p2 <= r_f2[FAC_W-1:0] * r_f3[FAC_W-1:0];
            end else begin
                r_p1 <= '0;
                r_p2 <= '0;
            end
        end
    end

    // Wide product split into two partial products.
    logic [PP_W-1:0]    r_pp_lo, r_pp_hi;
    logic [PERIM_W-1:0] r_perim_pp;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_pp_lo    <= r_p1[HALF_W-1:0] * r_p2;
            r_pp_hi    <= PP_W'(r_p1[PROD_W-1:HALF_W]) * PP_W'(r_p2);
            r_perim_pp <= r_perim_p;
        end
    end

    // Recombine into the Heron product.
    logic [Q_W-1:0]     r_q;
    logic [PERIM_W-1:0] r_perim_q;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_q       <= (Q_W'(r_pp_hi) << HALF_W) + Q_W'(r_pp_lo);
            r_perim_q <= r_perim_pp;
        end
    end

    // Area square root chain, perimeter travels alongside.
    t_sq_cell           s_area [AREA_CELLS+1];
    logic [PERIM_W-1:0] r_pd   [AREA_CELLS];

    assign s_area[0].rad  = r_q;
    assign s_area[0].rem  = '0;
    assign s_area[0].root = '0;

    for (genvar k = 0; k < AREA_CELLS; k++) begin : g_area
        tpa_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (s_en),
            .i_d   (s_area[k]),
            .o_q   (s_area[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_pd[0] <= r_perim_q;
            for (int k = 1; k < AREA_CELLS; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    // Output register with saturation.
    logic [ROOT_W-3:0] s_quarter;

    assign s_quarter = s_area[AREA_CELLS].root[ROOT_W-1:2];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            o_perimeter <= r_pd[AREA_CELLS-1];
            if (s_quarter > (ROOT_W-2)'({AREA_W{1'b1}})) begin
                o_tri_area <= '1;
            end else begin
                o_tri_area <= s_quarter[AREA_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/tpa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tpa_sqrt_cell: one restoring square-root step.
// Takes the next two radicand bits, decides one root bit and registers the
// partial remainder, partial root and remaining radicand for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_sqrt_cell (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire tpa_pkg::t_sq_cell i_d,
    output tpa_pkg::t_sq_cell      o_q
);
    import tpa_pkg::*;

    logic [REM_W-1:0] s_tmp;
    logic [REM_W-1:0] s_trial;
    logic             s_ge;
    t_sq_cell         n_q;
    t_sq_cell         r_q;

    // Bring down two radicand bits and compare against the trial divisor.
    always_comb begin
        s_tmp   = {i_d.rem[REM_W-3:0], i_d.rad[RAD_W-1 -: 2]};
        s_trial = {1'b0, i_d.root, 2'b01};
        s_ge    = (s_tmp >= s_trial);
        n_q.rad  = {i_d.rad[RAD_W-3:0], 2'b00};
        n_q.rem  = s_ge ? (s_tmp - s_trial) : s_tmp;
        n_q.root = {i_d.root[ROOT_W-2:0], s_ge};
    end

    // Stage register; payload only, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== design/tpa_checker.sv =====
// ----------------------------------------------------------------------------
// tpa_checker: port-level checks for the triangle perimeter/area unit.
// Watches only the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_ready,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [tpa_pkg::PERIM_W-1:0]  o_perimeter,
    input wire logic [tpa_pkg::AREA_W-1:0]   o_tri_area
);
    import tpa_pkg::*;

    // A waiting result item keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_perimeter) && $stable(o_tri_area)))
        else $error("result item changed while stalled");

    // No result item right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input side stalls only while the output is blocked.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input stalled without output backpressure");

    // A nonzero area needs a nonzero perimeter.
    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_tri_area != '0)) |-> (o_perimeter != '0))
        else $error("area without perimeter");

endmodule

bind triangle_perimeter_area_unit tpa_checker u_tpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_perimeter (o_perimeter),
    .o_tri_area  (o_tri_area)
);

`default_nettype wire

// ===== tb/sv/triangle_perimeter_area_unit_test.sv =====
// ----------------------------------------------------------------------------
// triangle_perimeter_area_unit_test: self-checking bench for the triangle unit.
// Sends vertex triples through the valid/ready input channel, computes the
// expected perimeter and Heron area with exact integer arithmetic, and checks
// every result item in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_perimeter_area_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tpa_pkg::*;

    localparam int LATENCY     = 61;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  tri_area;
    } t_shape;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy;
    logic   o_valid;
    logic   i_ready;
    logic [PERIM_W-1:0] o_perimeter;
    logic [AREA_W-1:0]  o_tri_area;

    t_shape shape_queue[$];
    int     mismatch_count;
    int     result_count;
    int     sent_count;
    int     cycle_count;
    int     degenerate_count;
    bit     hold_off_req;
    bit     hold_off_busy;

    triangle_perimeter_area_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by_coord (i_by_coord),
        .i_cx       (i_cx),
        .i_cy       (i_cy),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_perimeter(o_perimeter),
        .o_tri_area (o_tri_area)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor square root of a wide value, one root bit at a time.
    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if ({64'd0, t} * {64'd0, t} <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Truncated distance between two vertices.
    function automatic logic [63:0] edge_length(t_coord x0, t_coord y0, t_coord x1, t_coord y1);
        longint dx;
        longint dy;
        dx = longint'(x0) - longint'(x1);
        dy = longint'(y0) - longint'(y1);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return floor_sqrt(128'(dx * dx + dy * dy));
    endfunction

    // Expected perimeter and area of one triangle.
    function automatic t_shape triangle_shape(t_coord ax, t_coord ay, t_coord bx,
                                              t_coord by, t_coord cx, t_coord cy);
        longint      a, b, c, sum, f1, f2, f3;
        logic [127:0] q;
        logic [63:0]  area;
        t_shape       s;
        a   = longint'(edge_length(ax, ay, bx, by));
        b   = longint'(edge_length(ax, ay, cx, cy));
        c   = longint'(edge_length(bx, by, cx, cy));
        sum = a + b + c;
        f1  = -a + b + c;
        f2  = a - b + c;
        f3  = a + b - c;
        area = '0;
        // A flat or rounded-away triangle has zero area.
        if (f1 > 0 && f2 > 0 && f3 > 0) begin
            q    = 128'(sum * f1) * 128'(f2 * f3);
            area = floor_sqrt(q) >> 2;
        end
        s.perimeter = (sum > (1 << PERIM_W) - 1) ? '1 : sum[PERIM_W-1:0];
        s.tri_area  = (area > 64'h7fff_ffff) ? '1 : area[AREA_W-1:0];
        return s;
    endfunction

    // Send one item and record its expected result.
    task automatic send_triangle(t_coord ax, t_coord ay, t_coord bx,
                                 t_coord by, t_coord cx, t_coord cy);
        t_shape s;
        s = triangle_shape(ax, ay, bx, by, cx, cy);
        if (s.tri_area == 0) degenerate_count++;
        i_valid    <= 1'b1;
        i_ax       <= ax;
        i_ay       <= ay;
        i_bx       <= bx;
        i_by_coord <= by;
        i_cx       <= cx;
        i_cy       <= cy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shape_queue.push_back(s);
        sent_count++;
    endtask

    // Drop valid for a random gap; a zero gap keeps the stream going.
    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (shape_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord any_coord();
        return t_coord'($urandom_range(0, 65535));
    endfunction

    // Corners of the coordinate range and special shapes.
    task automatic test_directed();
        t_coord mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(mn, mn, mx, mx, mn, mx);
        send_triangle(mx, mx, mn, mn, mx, mn);
        send_triangle(mn, mn, mx, mn, mn, mx);
        send_triangle(mn, 0, mx, 0, 0, mx);
        send_triangle(mn, mn, mx, mx, 0, 0);
        send_triangle(0, 0, 256, 0, 0, 256);
        send_triangle(0, 0, 768, 0, 0, 1024);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, 1, 1, 2, 2);
        send_triangle(5, 5, 5, 5, 100, -100);
        send_triangle(0, 0, 3, 0, 1, 1);
        send_triangle(-1, -1, -1, -1, -1, -1);
        send_triangle(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 0, 0);
        send_triangle(mx, mx, mx, mx, mx, mn);
        send_triangle(mn, mx, mx, mn, mx, mx);
        send_triangle(100, 0, -100, 0, 0, 1);
        send_triangle(0, 0, 2, 1, 4, 2);
        wait_drained();
    endtask

    // Random triangles: as many full-range as small ones, and some flat.
    task automatic test_random(int count);
        t_coord ax, ay, bx, by, cx, cy;
        int     kind;
        int     span;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                ax = any_coord(); ay = any_coord(); bx = any_coord();
                by = any_coord(); cx = any_coord(); cy = any_coord();
            end else if (kind < 8) begin
                span = (1 << $urandom_range(1, 14));
                ax = any_coord() / 2;
                ay = any_coord() / 2;
                bx = ax + t_coord'($urandom_range(0, span)) - t_coord'(span / 2);
                by = ay + t_coord'($urandom_range(0, span)) - t_coord'(span / 2);
                cx = ax + t_coord'($urandom_range(0, span)) - t_coord'(span / 2);
                cy = ay + t_coord'($urandom_range(0, span)) - t_coord'(span / 2);
            end else begin
                // Collinear or repeated vertices.
                ax = any_coord() / 4; ay = any_coord() / 4;
                bx = ax + t_coord'($urandom_range(0, 200)) - 16'sd100;
                by = ay + t_coord'($urandom_range(0, 200)) - 16'sd100;
                cx = bx + (bx - ax);
                cy = by + (by - ay);
            end
            send_triangle(ax, ay, bx, by, cx, cy);
            sender_gap();
        end
        wait_drained();
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int n = 0; n < 150; n++) begin
            send_triangle(any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord());
        end
        wait_drained();
    endtask

    // Receiver stall pattern and long hold-off.
    initial begin
        int phase;
        i_ready       = 1'b0;
        hold_off_busy = 1'b0;
        phase         = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_busy) begin
                hold_off_busy = 1'b1;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 1'b0;
                hold_off_busy = 1'b0;
            end
            phase = (phase + 1) % 200;
            if (phase < 60) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 2) != 0);
            end
            @(posedge i_clk);
        end
    end

    // Result checker.
    initial begin
        t_shape want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                result_count++;
                if (shape_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result item: perimeter %0d area %0d",
                                 o_perimeter, o_tri_area);
                end else begin
                    want = shape_queue.pop_front();
                    if (want.perimeter !== o_perimeter || want.tri_area !== o_tri_area) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: perimeter exp %0d got %0d, area exp %0d got %0d",
                                     want.perimeter, o_perimeter, want.tri_area, o_tri_area);
                    end
                end
            end
        end
    end

    // Run watchdog.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        mismatch_count   = 0;
        result_count     = 0;
        sent_count       = 0;
        degenerate_count = 0;
        hold_off_req     = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ax       = '0;
        i_ay       = '0;
        i_bx       = '0;
        i_by_coord = '0;
        i_cx       = '0;
        i_cy       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(750);

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d triangles and checked %0d results, %0d with zero area,",
                 sent_count, result_count, degenerate_count);
        $display("covering range corners, flat shapes and long output stalls.");
        if (mismatch_count == 0 && shape_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, shape_queue.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
